// File: hw/rtl/cbfm_pkg.sv
// Package with the frame manager's constants, codes and entry type.
`timescale 1ns / 1ps
package cbfm_pkg;
    localparam int NUM_FRAMES = 16;
    localparam int PIN_BITS = 16;
    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W = $clog2(2 * NUM_FRAMES + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    localparam logic [2:0] MODE_READ    = 3'd0;
    localparam logic [2:0] MODE_UNPIN   = 3'd1;
    localparam logic [2:0] MODE_NEW     = 3'd2;
    localparam logic [2:0] MODE_DISPOSE = 3'd3;
    localparam logic [2:0] MODE_FLUSH   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FRAME  = 2'd1;
    localparam logic [1:0] ST_NOT_PIN   = 2'd2;
    localparam logic [1:0] ST_PIN_FLUSH = 2'd3;

    // One frame's bookkeeping, held as one memory word.
    typedef struct packed {
        logic                valid;
        logic [15:0]         file;
        logic [31:0]         page;
        logic [PIN_BITS-1:0] pins;
        logic                refb;
        logic                dirty;
    } entry_t;
endpackage

// File: hw/rtl/clock_buffer_frame_manager.sv
// Top level of the buffer-pool frame manager with clock second-chance replacement.
// The frame table is read one frame at a time: each frame is read, then compared.
// A hit ends the scan at its frame; a read or new miss scans all frames, then
// sweeps up to 2 * NUM_FRAMES + 1 frames past the clock hand. Flush reads each frame in turn,
// stopping at a pinned frame of the file, and waits on each result transfer; one request is
// in work at a time, the next taken in the cycle after the last result. Reset is synchronous
// active low, then a clearing pass zeroes the table before input is taken.
`timescale 1ns / 1ps
module clock_buffer_frame_manager (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [15:0] s_file_id,
    input  logic [31:0] s_page_no,
    input  logic        s_dirty_mark,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_frame,
    output logic        m_hit,
    output logic [1:0]  m_status,
    output logic        m_write_back,
    output logic [15:0] m_wb_file_id,
    output logic [31:0] m_wb_page_no,
    output logic        m_fetch,
    output logic        m_last
);
    localparam int IW = cbfm_pkg::IDX_W;
    localparam int CW = cbfm_pkg::CNT_W;
    localparam int NF = cbfm_pkg::NUM_FRAMES;
    localparam int PW = cbfm_pkg::PIN_BITS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FIND_RD, S_FIND_CHK, S_ACT_RD, S_ACT,
        S_SW_RD, S_SW_CHK, S_FL_RD, S_FL_CHK, S_OUT
    } state_t;

    state_t state_reg;
    cbfm_pkg::entry_t mem [NF];
    cbfm_pkg::entry_t rd_reg;
    logic [IW-1:0] addr_reg, hand_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]  mode_reg;
    logic [15:0] file_reg;
    logic [31:0] page_reg;
    logic        dm_reg;
    logic        found_reg;
    logic        flush_end_reg;

    localparam logic [IW-1:0] LAST_IDX = IW'(NF - 1);

    function automatic logic [IW-1:0] inc(input logic [IW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + 1'b1;
    endfunction

    // Memory write port, driven by the sequencer.
    logic             we_reg;
    logic [IW-1:0]    wa_reg;
    cbfm_pkg::entry_t wd_reg;

    always_ff @(posedge aclk) begin
        if (we_reg) mem[wa_reg] <= wd_reg;
        rd_reg <= mem[addr_reg];
    end

    logic tag_eq;
    assign tag_eq = rd_reg.valid && rd_reg.file == file_reg && rd_reg.page == page_reg;

    assign s_ready = (state_reg == S_IDLE);

    // Sequencer: clears, scans, sweeps and emits results.
    always_ff @(posedge aclk) begin
        we_reg <= 1'b0;
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            hand_reg  <= LAST_IDX;
            m_valid   <= 1'b0;
            we_reg    <= 1'b1;
            wa_reg    <= '0;
            wd_reg    <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    we_reg <= 1'b1;
                    wd_reg <= '0;
                    wa_reg <= inc(wa_reg);
                    if (wa_reg == LAST_IDX) begin
                        we_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_mode;
                        file_reg  <= s_file_id;
                        page_reg  <= s_page_no;
                        dm_reg    <= s_dirty_mark;
                        addr_reg  <= '0;
                        found_reg <= 1'b0;
                        if (s_mode == cbfm_pkg::MODE_FLUSH) state_reg <= S_FL_RD;
                        else if (s_mode > cbfm_pkg::MODE_FLUSH) state_reg <= S_IDLE;
                        else state_reg <= S_FIND_RD;
                    end
                end
                S_FIND_RD: state_reg <= S_FIND_CHK;
                S_FIND_CHK: begin
                    if (tag_eq) begin
                        found_reg <= 1'b1;
                        state_reg <= S_ACT;
                    end else if (addr_reg == LAST_IDX) begin
                        state_reg <= S_ACT;
                    end else begin
                        addr_reg  <= inc(addr_reg);
                        state_reg <= S_FIND_RD;
                    end
                end
                S_ACT: begin
                    m_frame <= 4'(addr_reg); m_hit <= 1'b1; m_status <= cbfm_pkg::ST_OK;
                    m_write_back <= 1'b0; m_wb_file_id <= '0; m_wb_page_no <= '0;
                    m_fetch <= 1'b0; m_last <= 1'b1;
                    wa_reg <= addr_reg; wd_reg <= rd_reg;
                    state_reg <= S_OUT;
                    if (!found_reg) begin
                        if (mode_reg == cbfm_pkg::MODE_READ || mode_reg == cbfm_pkg::MODE_NEW) begin
                            addr_reg  <= inc(hand_reg);
                            hand_reg  <= inc(hand_reg);
                            cnt_reg   <= CW'(2 * NF);
                            state_reg <= S_SW_RD;
                        end else begin
                            m_frame <= '0; m_hit <= 1'b0;
                        end
                    end else begin
                        unique case (mode_reg)
                            cbfm_pkg::MODE_READ, cbfm_pkg::MODE_NEW: begin
                                we_reg <= 1'b1;
                                wd_reg.refb <= 1'b1;
                                if (rd_reg.pins != cbfm_pkg::PIN_MAX)
                                    wd_reg.pins <= rd_reg.pins + 1'b1;
                            end
                            cbfm_pkg::MODE_UNPIN: begin
                                if (rd_reg.pins == '0) m_status <= cbfm_pkg::ST_NOT_PIN;
                                else begin
                                    we_reg <= 1'b1;
                                    wd_reg.pins  <= rd_reg.pins - 1'b1;
                                    wd_reg.dirty <= rd_reg.dirty | dm_reg;
                                end
                            end
                            default: begin
                                we_reg <= 1'b1; wd_reg <= '0;
                            end
                        endcase
                    end
                end
                S_SW_RD: state_reg <= S_SW_CHK;
                S_SW_CHK: begin
                    wa_reg <= addr_reg;
                    m_frame <= 4'(addr_reg); m_hit <= 1'b0; m_status <= cbfm_pkg::ST_OK;
                    m_write_back <= 1'b0; m_wb_file_id <= '0; m_wb_page_no <= '0;
                    m_fetch <= (mode_reg == cbfm_pkg::MODE_READ); m_last <= 1'b1;
                    wd_reg.valid <= 1'b1; wd_reg.file <= file_reg; wd_reg.page <= page_reg;
                    wd_reg.pins <= PW'(1); wd_reg.refb <= 1'b1; wd_reg.dirty <= 1'b0;
                    if (cnt_reg == '0) begin
                        m_frame <= '0; m_status <= cbfm_pkg::ST_NO_FRAME; m_fetch <= 1'b0;
                        state_reg <= S_OUT;
                    end else if (!rd_reg.valid) begin
                        we_reg <= 1'b1; state_reg <= S_OUT;
                    end else if (rd_reg.refb || rd_reg.pins != '0) begin
                        if (rd_reg.refb) begin
                            we_reg <= 1'b1; wd_reg <= rd_reg; wd_reg.refb <= 1'b0;
                        end
                        cnt_reg   <= cnt_reg - 1'b1;
                        addr_reg  <= inc(addr_reg);
                        hand_reg  <= inc(addr_reg);
                        state_reg <= S_SW_RD;
                    end else begin
                        we_reg <= 1'b1;
                        if (rd_reg.dirty) begin
                            m_write_back <= 1'b1;
                            m_wb_file_id <= rd_reg.file;
                            m_wb_page_no <= rd_reg.page;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_FL_RD: state_reg <= S_FL_CHK;
                S_FL_CHK: begin
                    m_frame <= 4'(addr_reg); m_hit <= 1'b1; m_status <= cbfm_pkg::ST_OK;
                    m_write_back <= 1'b0; m_wb_file_id <= '0; m_wb_page_no <= '0;
                    m_fetch <= 1'b0; m_last <= 1'b0;
                    wa_reg <= addr_reg; wd_reg <= '0;
                    flush_end_reg <= (addr_reg == LAST_IDX);
                    addr_reg <= inc(addr_reg);
                    state_reg <= (addr_reg == LAST_IDX) ? S_OUT : S_FL_RD;
                    if (rd_reg.valid && rd_reg.file == file_reg) begin
                        if (rd_reg.pins != '0) begin
                            m_status <= cbfm_pkg::ST_PIN_FLUSH; m_last <= 1'b1;
                            m_valid <= 1'b1; flush_end_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end else begin
                            we_reg <= 1'b1;
                            if (rd_reg.dirty) begin
                                m_write_back <= 1'b1;
                                m_wb_file_id <= rd_reg.file;
                                m_wb_page_no <= rd_reg.page;
                                m_valid <= 1'b1;
                                state_reg <= S_OUT;
                            end
                        end
                    end
                    if (addr_reg == LAST_IDX && !(rd_reg.valid && rd_reg.file == file_reg
                        && (rd_reg.pins != '0 || rd_reg.dirty))) begin
                        m_frame <= '0; m_hit <= 1'b0; m_last <= 1'b1; m_valid <= 1'b1;
                        flush_end_reg <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (mode_reg != cbfm_pkg::MODE_FLUSH && !m_valid) begin
                        m_valid <= 1'b1;
                    end else if (m_valid && m_ready) begin
                        m_valid <= 1'b0;
                        if (m_last) state_reg <= S_IDLE;
                        else if (flush_end_reg) begin
                            m_frame <= '0; m_hit <= 1'b0; m_write_back <= 1'b0;
                            m_wb_file_id <= '0; m_wb_page_no <= '0; m_last <= 1'b1;
                            m_valid <= 1'b1; flush_end_reg <= 1'b0;
                        end else state_reg <= S_FL_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while a result waits");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_frame) && $stable(m_last))
        else $error("result changed while stalled");
    a_wb_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_write_back) |-> (m_wb_file_id == '0 && m_wb_page_no == '0))
        else $error("write-back tag without write-back");
`endif
endmodule
